// ===== rtl/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// Types, codes and helpers for the hex record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ihex_pkg;

    localparam logic [7:0] CHAR_COLON   = 8'h3a;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        PH_AWAIT,
        PH_LEN,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_CSUM,
        PH_SKIP
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_NO_COLON   = 4'd1,
        ST_LEN_DIGIT  = 4'd2,
        ST_ADDR_DIGIT = 4'd3,
        ST_TYPE_DIGIT = 4'd4,
        ST_BAD_TYPE   = 4'd5,
        ST_DATA_DIGIT = 4'd6,
        ST_CSUM_DIGIT = 4'd7,
        ST_CSUM_BAD   = 4'd8
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_address;
        logic        rec_type;
        logic [7:0]  record_length;
        logic [3:0]  status;
    } t_result;

    // msb set when the character is not a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/intel_hex_record_parser_unit.sv =====
// a result is registered into the output register from the character transfer
// that causes it, or into the skid register while the output is stalled
// throughput: one character per cycle while the skid register is empty; a skid
// register behind the output register holds one more result while a result is stalled
// reset: synchronous active-low, returns to waiting for a colon
// ----------------------------------------------------------------------------
// intel_hex_record_parser_unit
// Hex record text parser with registered, stallable result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module intel_hex_record_parser_unit
    import ihex_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_char_code,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_result_kind,
    output logic [7:0]       o_data_byte,
    output logic [15:0]      o_byte_address,
    output logic             o_rec_type,
    output logic [7:0]       o_record_length,
    output logic [3:0]       o_status
);

    logic    take;
    logic    res_valid;
    t_result res;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_in_stall = r_skid_valid;
    assign take       = i_in_valid && !r_skid_valid;

    ihex_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char_code (i_char_code),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            // output register free after this edge
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out.kind;
    assign o_data_byte     = r_out.data_byte;
    assign o_byte_address  = r_out.byte_address;
    assign o_rec_type      = r_out.rec_type;
    assign o_record_length = r_out.record_length;
    assign o_status        = r_out.status;

endmodule

`default_nettype wire

// ===== rtl/ihex_core.sv =====
// ----------------------------------------------------------------------------
// ihex_core
// Record state machine: one character per transfer, at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_core
    import ihex_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_char_code,
    output logic            o_res_valid,
    output t_result         o_res
);

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_dcnt,   n_dcnt;
    logic [3:0]  r_high,   n_high;
    logic [7:0]  r_len,    n_len;
    logic [15:0] r_addr,   n_addr;
    logic        r_type,   n_type;
    logic [7:0]  r_left,   n_left;
    logic [7:0]  r_sum,    n_sum;

    logic [4:0]  hex;
    logic        not_hex;
    logic [3:0]  nib;
    logic [7:0]  byte_val;
    logic [15:0] addr_shift;
    logic        is_nl;
    logic        end_rec;
    logic [3:0]  end_status;
    logic        data_out;

    assign hex        = hex_decode(i_char_code);
    assign not_hex    = hex[4];
    assign nib        = hex[3:0];
    assign byte_val   = {r_high, nib};
    assign addr_shift = {r_addr[11:0], nib};
    assign is_nl      = (i_char_code == CHAR_NEWLINE);

    // which characters close a record, and with what status, and which emit a data byte
    always_comb begin
        end_rec    = 1'b0;
        end_status = ST_OK;
        data_out   = 1'b0;
        case (r_phase)
            PH_AWAIT: begin
                if (i_char_code != CHAR_COLON) begin
                    end_rec    = 1'b1;
                    end_status = ST_NO_COLON;
                end
            end
            PH_LEN: begin
                if (not_hex) begin
                    end_rec    = 1'b1;
                    end_status = ST_LEN_DIGIT;
                end
            end
            PH_ADDR: begin
                if (not_hex) begin
                    end_rec    = 1'b1;
                    end_status = ST_ADDR_DIGIT;
                end
            end
            PH_TYPE: begin
                if (not_hex) begin
                    end_rec    = 1'b1;
                    end_status = ST_TYPE_DIGIT;
                end else if (r_dcnt != 2'd0 && byte_val > 8'd1) begin
                    end_rec    = 1'b1;
                    end_status = ST_BAD_TYPE;
                end
            end
            PH_DATA: begin
                if (not_hex) begin
                    end_rec    = 1'b1;
                    end_status = ST_DATA_DIGIT;
                end else if (r_dcnt != 2'd0) begin
                    data_out = 1'b1;
                end
            end
            PH_CSUM: begin
                if (not_hex) begin
                    end_rec    = 1'b1;
                    end_status = ST_CSUM_DIGIT;
                end else if (r_dcnt != 2'd0) begin
                    end_rec    = 1'b1;
                    end_status = (8'(8'd0 - r_sum) == byte_val) ? ST_OK : ST_CSUM_BAD;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_dcnt  = r_dcnt;
        n_high  = r_high;
        n_len   = r_len;
        n_addr  = r_addr;
        n_type  = r_type;
        n_left  = r_left;
        n_sum   = r_sum;
        if (end_rec) begin
            n_phase = is_nl ? PH_AWAIT : PH_SKIP;
            n_dcnt  = 2'd0;
        end else begin
            case (r_phase)
                PH_AWAIT: begin
                    n_len   = 8'd0;
                    n_addr  = 16'd0;
                    n_type  = 1'b0;
                    n_sum   = 8'd0;
                    n_left  = 8'd0;
                    n_dcnt  = 2'd0;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (r_dcnt == 2'd0) begin
                        n_high = nib;
                        n_dcnt = 2'd1;
                    end else begin
                        n_dcnt  = 2'd0;
                        n_len   = byte_val;
                        n_sum   = r_sum + byte_val;
                        n_phase = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    n_addr = addr_shift;
                    if (r_dcnt[0]) begin
                        n_sum = r_sum + addr_shift[7:0];
                    end
                    if (r_dcnt == 2'd3) begin
                        n_phase = PH_TYPE;
                    end
                    n_dcnt = r_dcnt + 2'd1;
                end
                PH_TYPE: begin
                    if (r_dcnt == 2'd0) begin
                        n_high = nib;
                        n_dcnt = 2'd1;
                    end else begin
                        n_dcnt  = 2'd0;
                        n_type  = byte_val[0];
                        n_sum   = r_sum + byte_val;
                        n_left  = r_len;
                        n_phase = (r_len == 8'd0) ? PH_CSUM : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (r_dcnt == 2'd0) begin
                        n_high = nib;
                        n_dcnt = 2'd1;
                    end else begin
                        n_dcnt = 2'd0;
                        n_sum  = r_sum + byte_val;
                        n_addr = r_addr + 16'd1;
                        n_left = r_left - 8'd1;
                        if (r_left == 8'd1) begin
                            n_phase = PH_CSUM;
                        end
                    end
                end
                PH_CSUM: begin
                    // only the first checksum digit lands here
                    n_high = nib;
                    n_dcnt = 2'd1;
                end
                PH_SKIP: begin
                    if (is_nl) begin
                        n_phase = PH_AWAIT;
                    end
                end
                default: begin
                    n_phase = PH_AWAIT;
                    n_dcnt  = 2'd0;
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_res_valid          = i_take && (end_rec || data_out);
        o_res.kind           = end_rec ? KIND_END : KIND_DATA;
        o_res.data_byte      = end_rec ? 8'd0 : byte_val;
        o_res.byte_address   = end_rec ? 16'd0 : r_addr;
        o_res.rec_type       = r_type;
        o_res.record_length  = r_len;
        o_res.status         = end_rec ? end_status : ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_AWAIT;
            r_dcnt  <= 2'd0;
            r_high  <= 4'd0;
            r_len   <= 8'd0;
            r_addr  <= 16'd0;
            r_type  <= 1'b0;
            r_left  <= 8'd0;
            r_sum   <= 8'd0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_dcnt  <= n_dcnt;
            r_high  <= n_high;
            r_len   <= n_len;
            r_addr  <= n_addr;
            r_type  <= n_type;
            r_left  <= n_left;
            r_sum   <= n_sum;
        end
    end

endmodule

`default_nettype wire
